>>> rtl/command_frame_receiver_top_assert.svh
// Assertion macros for the command frame receiver.
// Used by files that check their own logic; expects aclk and aresetn in scope.
`ifndef COMMAND_FRAME_RECEIVER_TOP_ASSERT_SVH
`define COMMAND_FRAME_RECEIVER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cfr_pkg.sv
// Shared types, constants and the CRC byte update for the command frame receiver.
// No dependencies.
package cfr_pkg;

    localparam int TICK_COUNTER_BITS = 16;
    localparam int STORE_DEPTH       = 7;
    localparam int CFG_ADDR_BITS     = 3;
    localparam int CFG_DATA_BITS     = 16;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Word kinds
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SYNC_FIRST    = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SYNC_SECOND   = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_COMMAND_CODE  = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_LENGTH    = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TIMEOUT_TICKS = 3'd4;

    // Configuration reset values
    localparam logic [7:0]  SYNC_FIRST_RST    = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND_RST   = 8'h55;
    localparam logic [7:0]  COMMAND_CODE_RST  = 8'h01;
    localparam logic [7:0]  MAX_LENGTH_RST    = 8'd32;
    localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd100;

    localparam logic [7:0] STORE_LENGTH = 8'(STORE_DEPTH);
    localparam logic [7:0] POS_MAX      = 8'hFF;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } cfr_in_t;

    typedef struct packed {
        logic signed [15:0] force_res;
        logic [15:0]        force_limit;
        logic [15:0]        loop_gain;
        logic [7:0]         mode_command;
    } cfr_out_t;

    // Parser states, one-hot
    typedef enum logic [7:0] {
        ST_SYNC1   = 8'b0000_0001,
        ST_SYNC2   = 8'b0000_0010,
        ST_LEN     = 8'b0000_0100,
        ST_SEQ     = 8'b0000_1000,
        ST_CMD     = 8'b0001_0000,
        ST_PAYLOAD = 8'b0010_0000,
        ST_CRC_LO  = 8'b0100_0000,
        ST_CRC_HI  = 8'b1000_0000
    } cfr_state_t;

    // CRC-16 update over one byte, MSB first, poly 0x1021
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

>>> rtl/cfr_in_reg.sv
// Input register of the command frame receiver: holds one word for the parser.
// Depends on cfr_pkg.
module cfr_in_reg
    import cfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  cfr_in_t s_word,
    input  logic    take,
    output logic    q_valid,
    output cfr_in_t q_word
);

    logic    valid_reg;
    logic    valid_next;
    cfr_in_t word_reg;

    // Free when empty or when the held word moves on this cycle
    assign s_ready    = !valid_reg || take;
    assign valid_next = s_valid ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_word;
        end
    end

    assign q_valid = valid_reg;
    assign q_word  = word_reg;

endmodule

>>> rtl/cfr_out_reg.sv
// Result register of the command frame receiver.
// Depends on cfr_pkg.
module cfr_out_reg
    import cfr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     load,
    input  cfr_out_t load_word,
    output logic     free,
    output logic     m_valid,
    input  logic     m_ready,
    output cfr_out_t m_word
);

    logic     valid_reg;
    logic     valid_next;
    cfr_out_t word_reg;

    // Can take a result when empty or being drained
    assign free       = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= load_word;
        end
    end

    assign m_valid = valid_reg;
    assign m_word  = word_reg;

endmodule

>>> rtl/cfr_parser.sv
// Frame parser: config registers, sync/length/command tracking, CRC, payload
// store and idle tick counter. Depends on cfr_pkg and the assertion macros.
`include "command_frame_receiver_top_assert.svh"

module cfr_parser
    import cfr_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     step,
    input  cfr_in_t                  word,
    output logic                     res_valid,
    output cfr_out_t                 res_word
);

    // Configuration
    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [7:0]  command_code_reg;
    logic [7:0]  max_length_reg;
    logic [15:0] timeout_ticks_reg;

    // Parser state
    cfr_state_t                   state_reg, state_next;
    logic [7:0]                   len_reg, len_next;
    logic [7:0]                   cmd_reg, cmd_next;
    logic [7:0]                   pos_reg, pos_next;
    logic [15:0]                  crc_reg, crc_next;
    logic [7:0]                   crc_lo_reg, crc_lo_next;
    logic [TICK_COUNTER_BITS-1:0] idle_reg, idle_next;
    logic [7:0]                   store_reg [STORE_DEPTH];

    logic [7:0]                   b;
    logic [7:0]                   pos_inc;
    logic [TICK_COUNTER_BITS-1:0] idle_inc;
    logic                         store_we;
    logic                         frame_ok;

    assign b        = word.rx_byte;
    assign pos_inc  = (pos_reg != POS_MAX) ? pos_reg + 8'd1 : pos_reg;
    assign idle_inc = (idle_reg != {TICK_COUNTER_BITS{1'b1}})
                      ? idle_reg + TICK_COUNTER_BITS'(1) : idle_reg;
    assign frame_ok = ({b, crc_lo_reg} == crc_reg) && (cmd_reg == command_code_reg)
                      && (len_reg == STORE_LENGTH);

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg    <= SYNC_FIRST_RST;
            sync_second_reg   <= SYNC_SECOND_RST;
            command_code_reg  <= COMMAND_CODE_RST;
            max_length_reg    <= MAX_LENGTH_RST;
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_SYNC_FIRST:    sync_first_reg    <= cfg_wdata[7:0];
                CFG_SYNC_SECOND:   sync_second_reg   <= cfg_wdata[7:0];
                CFG_COMMAND_CODE:  command_code_reg  <= cfg_wdata[7:0];
                CFG_MAX_LENGTH:    max_length_reg    <= cfg_wdata[7:0];
                CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Next-state logic for one word
    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        cmd_next    = cmd_reg;
        pos_next    = pos_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        idle_next   = idle_reg;
        store_we    = 1'b0;
        res_valid   = 1'b0;
        if (step) begin
            if (word.action == ACT_TICK) begin
                // idle tick: saturating count, abandon a stale partial frame
                idle_next = idle_inc;
                if (state_reg != ST_SYNC1 && 32'(idle_inc) > 32'(timeout_ticks_reg)) begin
                    state_next = ST_SYNC1;
                    pos_next   = 8'd0;
                end
            end else begin
                idle_next = '0;
                unique case (state_reg)
                    ST_SYNC1: begin
                        if (b == sync_first_reg) begin
                            state_next = ST_SYNC2;
                        end
                    end
                    ST_SYNC2: begin
                        priority if (b == sync_second_reg) begin
                            state_next = ST_LEN;
                        end else if (b != sync_first_reg) begin
                            state_next = ST_SYNC1;
                        end else begin
                            state_next = ST_SYNC2;
                        end
                    end
                    ST_LEN: begin
                        if (b > max_length_reg) begin
                            state_next = ST_SYNC1;
                            pos_next   = 8'd0;
                        end else begin
                            len_next   = b;
                            state_next = ST_SEQ;
                        end
                    end
                    ST_SEQ: begin
                        state_next = ST_CMD;
                    end
                    ST_CMD: begin
                        cmd_next   = b;
                        pos_next   = 8'd0;
                        crc_next   = CRC_INIT;
                        state_next = (len_reg != 8'd0) ? ST_PAYLOAD : ST_CRC_LO;
                    end
                    ST_PAYLOAD: begin
                        crc_next = crc_byte(crc_reg, b);
                        store_we = (pos_reg < STORE_LENGTH);
                        pos_next = pos_inc;
                        if (pos_inc >= len_reg) begin
                            state_next = ST_CRC_LO;
                        end
                    end
                    ST_CRC_LO: begin
                        crc_lo_next = b;
                        state_next  = ST_CRC_HI;
                    end
                    ST_CRC_HI: begin
                        state_next = ST_SYNC1;
                        pos_next   = 8'd0;
                        res_valid  = frame_ok;
                    end
                    default: begin
                        state_next = ST_SYNC1;
                        pos_next   = 8'd0;
                    end
                endcase
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_SYNC1;
            len_reg    <= 8'd0;
            cmd_reg    <= 8'd0;
            pos_reg    <= 8'd0;
            crc_reg    <= CRC_INIT;
            crc_lo_reg <= 8'd0;
            idle_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            cmd_reg    <= cmd_next;
            pos_reg    <= pos_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
            idle_reg   <= idle_next;
        end
    end

    // Payload store, first seven bytes only
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[pos_reg[2:0]] <= b;
        end
    end

    // Little-endian field decode
    assign res_word.force_res    = $signed({store_reg[1], store_reg[0]});
    assign res_word.force_limit  = {store_reg[3], store_reg[2]};
    assign res_word.loop_gain    = {store_reg[5], store_reg[4]};
    assign res_word.mode_command = store_reg[6];

    `CFR_ASSERT_IMP(a_res_only_crc_hi, res_valid,
        step && state_reg == ST_CRC_HI && word.action == ACT_BYTE,
        "result outside CRC high byte")
    `CFR_ASSERT_NXT(a_crc_hi_resets, step && word.action == ACT_BYTE && state_reg == ST_CRC_HI,
        state_reg == ST_SYNC1 && pos_reg == 8'd0,
        "parser not reset after CRC high byte")
    `CFR_ASSERT_IMP(a_pos_in_payload, state_reg == ST_PAYLOAD,
        pos_reg < len_reg,
        "payload position past length")
    `CFR_ASSERT_NXT(a_byte_clears_idle, step && word.action == ACT_BYTE,
        idle_reg == '0,
        "idle count not cleared by byte")

endmodule

>>> rtl/command_frame_receiver_top.sv
// A word held in the input register steps the parser; a good frame's result is
// loaded into the result register. One word per cycle while the result register
// can take a result; it drains while the next word is taken.
// Reset (aresetn low, synchronous): parser waits for first sync, idle count zero,
// config back to defaults, both registers empty; the payload store is not cleared.
// Top level of the command frame receiver; depends on cfr_pkg, cfr_in_reg,
// cfr_parser and cfr_out_reg.
module command_frame_receiver_top
    import cfr_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  cfr_in_t                  s_word,
    output logic                     m_valid,
    input  logic                     m_ready,
    output cfr_out_t                 m_word
);

    logic     q_valid;
    cfr_in_t  q_word;
    logic     out_free;
    logic     step;
    logic     res_valid;
    cfr_out_t res_word;

    // Parser advances when a word is held and the result register can take one
    assign step = q_valid && out_free;

    cfr_in_reg u_in (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .take    (step),
        .q_valid (q_valid),
        .q_word  (q_word)
    );

    cfr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .word      (q_word),
        .res_valid (res_valid),
        .res_word  (res_word)
    );

    cfr_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .load_word (res_word),
        .free      (out_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for command_frame_receiver_top: frames and ticks go in,
// decoded commands are checked against an in-bench deframer model.
// Depends on cfr_pkg and the RTL of command_frame_receiver_top only.
module testbench;
    import cfr_pkg::*;

    localparam int CYCLE_LIMIT   = 900_000;
    localparam int RANDOM_WORDS  = 1200;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_WORDS   = RANDOM_WORDS / RAND_PHASES;

    typedef enum {CLEAN, BAD_CRC, CUT_SHORT} frame_fault_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    cfr_in_t                  s_word;
    logic                     m_valid;
    logic                     m_ready;
    cfr_out_t                 m_word;

    command_frame_receiver_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    // Deframer model: register copies and parser state
    logic [7:0]                   sync_a     = SYNC_FIRST_RST;
    logic [7:0]                   sync_b     = SYNC_SECOND_RST;
    logic [7:0]                   cmd_code   = COMMAND_CODE_RST;
    logic [7:0]                   len_limit  = MAX_LENGTH_RST;
    logic [15:0]                  tick_limit = TIMEOUT_TICKS_RST;
    cfr_state_t                   prs        = ST_SYNC1;
    logic [7:0]                   frame_len  = '0;
    logic [7:0]                   frame_cmd  = '0;
    logic [7:0]                   pos        = '0;
    logic [15:0]                  crc_acc    = CRC_INIT;
    logic [7:0]                   crc_lo     = '0;
    logic [7:0]                   store [STORE_DEPTH];
    logic [TICK_COUNTER_BITS-1:0] idle_cnt   = '0;

    cfr_out_t   expected_cmds [$];
    logic [7:0] payload_buf [256];

    int errors          = 0;
    int cycles          = 0;
    int words_sent      = 0;
    int ticks_sent      = 0;
    int frames_sent     = 0;
    int results_checked = 0;
    int settings_run    = 0;
    int tx_calm         = 0;
    int rx_calm         = 0;
    bit tx_rush         = 1'b0;

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Bit-serial CRC-16, poly 0x1021, MSB first
    function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] d);
        logic fb;
        for (int k = 7; k >= 0; k--) begin
            fb  = acc[15] ^ d[k];
            acc = {acc[14:0], 1'b0};
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic void drop_frame();
        prs = ST_SYNC1;
        pos = '0;
    endfunction

    // Advance the model by one accepted word; queue a command when a frame completes
    function automatic void deframe_word(cfr_in_t w);
        logic [15:0] rx_crc;
        cfr_out_t    cmd;
        if (w.action == ACT_TICK) begin
            if (idle_cnt != '1) begin
                idle_cnt++;
            end
            if (prs != ST_SYNC1 && idle_cnt > tick_limit) begin
                drop_frame();
            end
            return;
        end
        idle_cnt = '0;
        case (prs)
            ST_SYNC1: begin
                if (w.rx_byte == sync_a) prs = ST_SYNC2;
            end
            ST_SYNC2: begin
                if (w.rx_byte == sync_b) prs = ST_LEN;
                else if (w.rx_byte != sync_a) prs = ST_SYNC1;
            end
            ST_LEN: begin
                if (w.rx_byte > len_limit) begin
                    drop_frame();
                end else begin
                    frame_len = w.rx_byte;
                    prs       = ST_SEQ;
                end
            end
            ST_SEQ: begin
                prs = ST_CMD;
            end
            ST_CMD: begin
                frame_cmd = w.rx_byte;
                pos       = '0;
                crc_acc   = CRC_INIT;
                prs       = (frame_len != 0) ? ST_PAYLOAD : ST_CRC_LO;
            end
            ST_PAYLOAD: begin
                crc_acc = crc16_step(crc_acc, w.rx_byte);
                if (pos < STORE_DEPTH) store[pos] = w.rx_byte;
                if (pos != POS_MAX) pos++;
                if (pos >= frame_len) prs = ST_CRC_LO;
            end
            ST_CRC_LO: begin
                crc_lo = w.rx_byte;
                prs    = ST_CRC_HI;
            end
            default: begin
                rx_crc = {w.rx_byte, crc_lo};
                drop_frame();
                if (rx_crc == crc_acc && frame_cmd == cmd_code && frame_len == STORE_LENGTH) begin
                    cmd.force_res    = {store[1], store[0]};
                    cmd.force_limit  = {store[3], store[2]};
                    cmd.loop_gain    = {store[5], store[4]};
                    cmd.mode_command = store[6];
                    expected_cmds.push_back(cmd);
                end
            end
        endcase
    endfunction

    // Idle length for one word: mostly short, sometimes long, with calm stretches
    function automatic int draw_wait(inout int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 1) ? $urandom_range(0, 18) : $urandom_range(0, 2);
    endfunction

    function automatic cfr_in_t byte_word(logic [7:0] b);
        cfr_in_t w;
        w.action  = ACT_BYTE;
        w.rx_byte = b;
        return w;
    endfunction

    function automatic cfr_in_t tick_word();
        cfr_in_t w;
        w.action  = ACT_TICK;
        w.rx_byte = 8'($urandom);
        return w;
    endfunction

    // Present one word and hold it until accepted
    task automatic send_word(cfr_in_t w);
        int gap;
        gap = tx_rush ? 0 : draw_wait(tx_calm);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) begin
                s_word = 9'($urandom);
                @(negedge aclk);
            end
        end
        s_word  = w;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        deframe_word(w);
        words_sent++;
        if (w.action == ACT_TICK) ticks_sent++;
    endtask

    // Release the input and wait until every queued command has come out
    task automatic drain_commands();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge aclk);
        s_valid   = 1'b0;
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_we    = 1'b0;
        cfg_addr  = CFG_ADDR_BITS'($urandom);
        cfg_wdata = CFG_DATA_BITS'($urandom);
        case (idx)
            CFG_SYNC_FIRST:    sync_a     = data[7:0];
            CFG_SYNC_SECOND:   sync_b     = data[7:0];
            CFG_COMMAND_CODE:  cmd_code   = data[7:0];
            CFG_MAX_LENGTH:    len_limit  = data[7:0];
            CFG_TIMEOUT_TICKS: tick_limit = data;
            default: ;
        endcase
    endtask

    // Write every register (upper bits of narrow ones are junk) plus an unmapped index
    task automatic apply_config(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                logic [7:0] m, logic [15:0] t);
        drain_commands();
        set_reg(CFG_SYNC_FIRST,    {8'($urandom), a});
        set_reg(CFG_SYNC_SECOND,   {8'($urandom), b});
        set_reg(CFG_COMMAND_CODE,  {8'($urandom), c});
        set_reg(CFG_MAX_LENGTH,    {8'($urandom), m});
        set_reg(CFG_TIMEOUT_TICKS, t);
        set_reg(CFG_TIMEOUT_TICKS + CFG_ADDR_BITS'($urandom_range(1, 3)), 16'($urandom));
        settings_run++;
    endtask

    task automatic fill_payload(logic [7:0] len);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 7))
                0:       payload_buf[i] = 8'h00;
                1:       payload_buf[i] = 8'hFF;
                default: payload_buf[i] = 8'($urandom);
            endcase
        end
    endtask

    // Seven payload bytes, byte 0 in the low bits
    task automatic load_payload(logic [55:0] packed_bytes);
        for (int i = 0; i < STORE_DEPTH; i++) begin
            payload_buf[i] = packed_bytes[8*i +: 8];
        end
    endtask

    // Build a frame from payload_buf, optionally damaged, with ticks spliced in
    task automatic send_frame(logic [7:0] len, logic [7:0] cmd, frame_fault_t fault,
                              int tick_at, int tick_count);
        cfr_in_t     words [$];
        logic [15:0] crc;
        int          keep;
        crc = CRC_INIT;
        words.push_back(byte_word(sync_a));
        words.push_back(byte_word(sync_b));
        words.push_back(byte_word(len));
        words.push_back(byte_word(8'($urandom)));
        words.push_back(byte_word(cmd));
        for (int i = 0; i < len; i++) begin
            words.push_back(byte_word(payload_buf[i]));
            crc = crc16_step(crc, payload_buf[i]);
        end
        if (fault == BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        words.push_back(byte_word(crc[7:0]));
        words.push_back(byte_word(crc[15:8]));
        if (fault == CUT_SHORT) begin
            keep = $urandom_range(1, words.size() - 1);
            while (words.size() > keep) void'(words.pop_back());
        end
        if (tick_at > words.size() - 1) tick_at = words.size() - 1;
        frames_sent++;
        foreach (words[i]) begin
            if (i == tick_at) repeat (tick_count) send_word(tick_word());
            send_word(words[i]);
        end
    endtask

    // Bring the parser back to waiting for the first sync
    task automatic settle_parser();
        logic [7:0] filler;
        if (prs == ST_SYNC1) return;
        if (tick_limit < 30) begin
            repeat (tick_limit + 1) send_word(tick_word());
        end else begin
            while (prs != ST_SYNC1) begin
                do filler = 8'($urandom); while (filler == sync_a || filler == sync_b);
                send_word(byte_word(filler));
            end
        end
    endtask

    // Good frames at reset settings, field extremes, repeated first sync
    task automatic test_default_frames();
        load_payload(56'hFF_0000_FFFF_8000);
        send_frame(STORE_LENGTH, cmd_code, CLEAN, 0, 0);
        send_word(byte_word(sync_a));
        send_word(byte_word(sync_a));
        load_payload(56'h00_FFFF_0000_7FFF);
        send_frame(STORE_LENGTH, cmd_code, CLEAN, 0, 0);
        drain_commands();
    endtask

    // Frames the receiver must drop, each followed up so recovery is seen
    task automatic test_rejected_frames();
        // length one over the limit aborts the header
        send_word(byte_word(sync_a));
        send_word(byte_word(sync_b));
        send_word(byte_word(len_limit + 8'd1));
        fill_payload(STORE_LENGTH);
        send_frame(STORE_LENGTH, cmd_code, CLEAN, 0, 0);
        // lengths other than seven parse fully but give nothing
        fill_payload(len_limit);
        send_frame(len_limit, cmd_code, CLEAN, 0, 0);
        send_frame(8'd0, cmd_code, CLEAN, 0, 0);
        send_frame(8'd9, cmd_code, CLEAN, 0, 0);
        send_frame(8'd6, cmd_code, CLEAN, 0, 0);
        // wrong command byte, then a corrupted CRC
        fill_payload(STORE_LENGTH);
        send_frame(STORE_LENGTH, cmd_code ^ 8'h01, CLEAN, 0, 0);
        send_frame(STORE_LENGTH, cmd_code, BAD_CRC, 0, 0);
        send_frame(STORE_LENGTH, cmd_code, CLEAN, 0, 0);
        drain_commands();
    endtask

    // Idle ticks, and timeouts either side of the limit
    task automatic test_tick_timeout();
        repeat (3) send_word(tick_word());
        drain_commands();
        set_reg(CFG_TIMEOUT_TICKS, 16'd0);
        fill_payload(STORE_LENGTH);
        send_frame(STORE_LENGTH, cmd_code, CLEAN, 2, 1);
        settle_parser();
        send_frame(STORE_LENGTH, cmd_code, CLEAN, 0, 0);
        drain_commands();
        set_reg(CFG_TIMEOUT_TICKS, 16'd3);
        fill_payload(STORE_LENGTH);
        send_frame(STORE_LENGTH, cmd_code, CLEAN, 6, 3);
        send_frame(STORE_LENGTH, cmd_code, CLEAN, 8, 4);
        settle_parser();
        drain_commands();
    endtask

    // Both sync registers equal: the second-sync match takes priority
    task automatic test_equal_sync();
        apply_config(8'h5A, 8'h5A, cmd_code, len_limit, tick_limit);
        fill_payload(STORE_LENGTH);
        send_word(byte_word(8'h5A));
        send_frame(STORE_LENGTH, cmd_code, CLEAN, 0, 0);
        settle_parser();
        send_frame(STORE_LENGTH, cmd_code, CLEAN, 0, 0);
        drain_commands();
    endtask

    // Wide timeouts: full scale never fires, a burst just over the limit does
    task automatic test_wide_timeout();
        tx_rush = 1'b1;
        drain_commands();
        set_reg(CFG_TIMEOUT_TICKS, 16'hFFFF);
        fill_payload(STORE_LENGTH);
        send_frame(STORE_LENGTH, cmd_code, CLEAN, 5, 120);
        drain_commands();
        set_reg(CFG_TIMEOUT_TICKS, 16'd60);
        send_frame(STORE_LENGTH, cmd_code, CLEAN, 5, 60);
        send_frame(STORE_LENGTH, cmd_code, CLEAN, 5, 61);
        settle_parser();
        send_frame(STORE_LENGTH, cmd_code, CLEAN, 0, 0);
        drain_commands();
        tx_rush = 1'b0;
    endtask

    // Mostly well-formed frames, plus broken frames, noise and tick bursts
    task automatic test_random_traffic();
        logic [7:0]   a, b, c, m, len, cmd;
        logic [15:0]  t;
        int           pick, budget_end, n;
        bit           paused;
        frame_fault_t fault;
        for (int p = 0; p < RAND_PHASES; p++) begin
            a = 8'($urandom);
            b = 8'($urandom);
            c = 8'($urandom);
            m = 8'($urandom_range(7, 48));
            t = 16'($urandom_range(4, 200));
            case (p)
                0: t = 16'd0;
                1: begin
                    a = 8'h00; b = 8'hFF; c = 8'h00; m = STORE_LENGTH; t = 16'd1;
                end
                2: begin
                    a = 8'hFF; b = 8'h00; c = 8'hFF; m = 8'hFF; t = 16'hFFFF;
                end
                3: b = a;
                4: m = 8'd0;
                5: m = STORE_LENGTH - 8'd1;
                default: ;
            endcase
            apply_config(a, b, c, m, t);
            budget_end = words_sent + PHASE_WORDS;
            paused     = 1'b0;
            while (words_sent < budget_end) begin
                // hold the sender off once per phase until the output is empty
                if (!paused && words_sent >= budget_end - PHASE_WORDS / 2) begin
                    drain_commands();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    settle_parser();
                    fill_payload(STORE_LENGTH);
                    send_frame(STORE_LENGTH, cmd_code, CLEAN, 0, 0);
                end else if (pick < 80) begin
                    settle_parser();
                    len   = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
                    cmd   = $urandom_range(0, 1) ? cmd_code : 8'($urandom);
                    fault = frame_fault_t'($urandom_range(0, 2));
                    n     = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
                    fill_payload(len);
                    send_frame(len, cmd, fault, $urandom_range(1, 12), n);
                end else if (pick < 92) begin
                    repeat ($urandom_range(1, 6)) begin
                        send_word(byte_word($urandom_range(0, 3) == 0 ? sync_a : 8'($urandom)));
                    end
                end else begin
                    n = (tick_limit < 38) ? $urandom_range(1, tick_limit + 2)
                                          : $urandom_range(1, 40);
                    repeat (n) send_word(tick_word());
                end
            end
            drain_commands();
        end
    endtask

    // Output side: random back-pressure per command
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_wait(rx_calm);
            @(negedge aclk);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Compare each accepted command with the oldest prediction
    always @(posedge aclk) begin
        cfr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_cmds.size() == 0) begin
                errors++;
                $error("command word with none predicted: %h", m_word);
            end else begin
                want = expected_cmds.pop_front();
                results_checked++;
                if (m_word.force_res !== want.force_res) begin
                    errors++;
                    $error("force_res: expected %0d, got %0d", want.force_res, m_word.force_res);
                end
                if (m_word.force_limit !== want.force_limit) begin
                    errors++;
                    $error("force_limit: expected %0d, got %0d",
                           want.force_limit, m_word.force_limit);
                end
                if (m_word.loop_gain !== want.loop_gain) begin
                    errors++;
                    $error("loop_gain: expected %0d, got %0d",
                           want.loop_gain, m_word.loop_gain);
                end
                if (m_word.mode_command !== want.mode_command) begin
                    errors++;
                    $error("mode_command: expected %0d, got %0d",
                           want.mode_command, m_word.mode_command);
                end
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_word    = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_default_frames();
        test_rejected_frames();
        test_tick_timeout();
        test_equal_sync();
        test_wide_timeout();
        test_random_traffic();

        drain_commands();
        repeat (10) @(posedge aclk);
        if (expected_cmds.size() != 0) begin
            errors++;
            $error("%0d predicted commands never arrived", expected_cmds.size());
        end
        $display("Sent %0d words (%0d ticks) forming %0d frames across %0d register settings.",
                 words_sent, ticks_sent, frames_sent, settings_run);
        $display("Checked %0d decoded commands in %0d cycles, %0d errors.",
                 results_checked, cycles, errors);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/cfr_pkg.sv
rtl/cfr_in_reg.sv
rtl/cfr_out_reg.sv
rtl/cfr_parser.sv
rtl/command_frame_receiver_top.sv
tb/sv/testbench.sv
